@@ design/esc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_HEX0 = 2'd2,
        PH_HEX1 = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_done;
        logic [15:0] out_length;
        logic        last_of_run;
    } res_t;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BSL = 8'h5c;
    localparam logic [7:0] CH_X   = 8'h78;

    localparam int unsigned REG_MAX_OUT_LEN = 0;
    localparam logic [15:0] MAX_OUT_LEN_RST = 16'hffff;

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66)
              || (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] t;
        if (b >= 8'h30 && b <= 8'h39) begin
            t = b - 8'h30;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            t = b - 8'h57;
        end else begin
            t = b - 8'h37;
        end
        hex_val = t[3:0];
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] b);
        case (b)
            8'h6e:   escape_map = 8'h0a;
            8'h72:   escape_map = 8'h0d;
            8'h61:   escape_map = 8'h07;
            8'h74:   escape_map = 8'h09;
            8'h62:   escape_map = 8'h08;
            8'h66:   escape_map = 8'h0c;
            8'h76:   escape_map = 8'h0b;
            default: escape_map = b;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ design/esc_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module esc_parser #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [7:0]    cur_byte,
    input  wire logic          advance,
    input  wire logic [15:0]   limit,
    output esc_pkg::res_t      res0,
    output esc_pkg::res_t      res1,
    output logic [1:0]         res_cnt
);

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    esc_pkg::phase_t         phase_reg, phase_next;
    logic [3:0]              nibble_reg, nibble_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;

    logic                    pre_put, mid_put, mid_done, use_plain;
    logic [7:0]              pre_val, mid_val;
    logic                    emit_a, emit_b, second_vld;
    logic [COUNT_BITS-1:0]   c1;
    logic [CMP_W-1:0]        c1_ext;
    logic                    hex;
    logic [3:0]              hv;
    esc_pkg::phase_t         plain_phase;
    esc_pkg::res_t           res_a, res_b;

    assign hex = esc_pkg::is_hex(cur_byte);
    assign hv  = esc_pkg::hex_val(cur_byte);
    assign plain_phase = (cur_byte == esc_pkg::CH_BSL) ? esc_pkg::PH_ESC : esc_pkg::PH_TEXT;

    // next state
    always_comb begin
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        unique case (phase_reg)
            esc_pkg::PH_TEXT: begin
                phase_next = plain_phase;
            end
            esc_pkg::PH_ESC: begin
                phase_next = (cur_byte == esc_pkg::CH_X) ? esc_pkg::PH_HEX0 : esc_pkg::PH_TEXT;
            end
            esc_pkg::PH_HEX0: begin
                if (hex) begin
                    phase_next  = esc_pkg::PH_HEX1;
                    nibble_next = hv;
                end else begin
                    phase_next = plain_phase;
                end
            end
            esc_pkg::PH_HEX1: begin
                nibble_next = 4'h0;
                phase_next  = hex ? esc_pkg::PH_TEXT : plain_phase;
            end
            default: begin
                phase_next = esc_pkg::PH_TEXT;
            end
        endcase
        if (mid_done) begin
            phase_next  = esc_pkg::PH_TEXT;
            nibble_next = 4'h0;
        end
    end

    // emitted bytes
    always_comb begin
        pre_put   = 1'b0;
        pre_val   = 8'h00;
        use_plain = 1'b0;
        mid_put   = 1'b0;
        mid_val   = 8'h00;
        mid_done  = 1'b0;
        unique case (phase_reg)
            esc_pkg::PH_TEXT: begin
                use_plain = 1'b1;
            end
            esc_pkg::PH_ESC: begin
                if (cur_byte == esc_pkg::CH_NUL) begin
                    mid_done = 1'b1;
                end else if (cur_byte != esc_pkg::CH_X) begin
                    mid_put = 1'b1;
                    mid_val = esc_pkg::escape_map(cur_byte);
                end
            end
            esc_pkg::PH_HEX0: begin
                if (!hex) begin
                    pre_put   = 1'b1;
                    pre_val   = esc_pkg::CH_X;
                    use_plain = 1'b1;
                end
            end
            esc_pkg::PH_HEX1: begin
                if (hex) begin
                    mid_put = 1'b1;
                    mid_val = {nibble_reg, hv};
                end else begin
                    pre_put   = 1'b1;
                    pre_val   = {4'h0, nibble_reg};
                    use_plain = 1'b1;
                end
            end
            default: begin
                use_plain = 1'b0;
            end
        endcase
        if (use_plain) begin
            if (cur_byte == esc_pkg::CH_NUL) begin
                mid_done = 1'b1;
            end else if (cur_byte != esc_pkg::CH_BSL) begin
                mid_put = 1'b1;
                mid_val = cur_byte;
            end
        end
    end

    // output limit and counter saturation
    assign emit_a = pre_put && (CMP_W'(count_reg) < CMP_W'(limit)) && (count_reg != '1);
    assign c1     = count_reg + COUNT_BITS'(emit_a);
    assign c1_ext = CMP_W'(c1);
    assign emit_b = mid_put && (c1_ext < CMP_W'(limit)) && (c1 != '1);
    assign second_vld = emit_b || mid_done;

    assign count_next = mid_done ? '0 : c1 + COUNT_BITS'(emit_b);

    always_comb begin
        res_a.out_byte    = pre_val;
        res_a.is_done     = 1'b0;
        res_a.out_length  = 16'h0000;
        res_a.last_of_run = !second_vld;
        res_b.out_byte    = mid_done ? 8'h00 : mid_val;
        res_b.is_done     = mid_done;
        res_b.out_length  = mid_done ? c1_ext[15:0] : 16'h0000;
        res_b.last_of_run = 1'b1;
        res0    = emit_a ? res_a : res_b;
        res1    = res_b;
        res_cnt = {1'b0, emit_a} + {1'b0, second_vld};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= esc_pkg::PH_TEXT;
            nibble_reg <= 4'h0;
            count_reg  <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ design/esc_res_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module esc_res_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire logic [1:0]    push_cnt,
    input  wire esc_pkg::res_t push0,
    input  wire esc_pkg::res_t push1,
    input  wire logic          pop,
    output esc_pkg::res_t      head,
    output logic               head_vld,
    output logic [1:0]         level
);

    esc_pkg::res_t slot0_reg, slot0_next;
    esc_pkg::res_t slot1_reg, slot1_next;
    logic [1:0]    level_reg, level_next;
    logic [1:0]    kept;
    logic          do_pop;

    assign do_pop = pop && (level_reg != 2'd0);
    assign kept   = level_reg - {1'b0, do_pop};

    always_comb begin
        slot0_next = do_pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        if (push) begin
            case (kept)
                2'd0: begin
                    slot0_next = push0;
                    slot1_next = push1;
                end
                2'd1: begin
                    slot1_next = push0;
                end
                default: begin
                    slot1_next = slot1_reg;
                end
            endcase
        end
        level_next = kept + (push ? push_cnt : 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 2'd0;
        end else begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign head     = slot0_reg;
    assign head_vld = (level_reg != 2'd0);
    assign level    = level_reg;

endmodule

`default_nettype wire

@@ design/escape_sequence_decoder.sv @@
// backslash escape decoder, one text byte per transaction on the s_ channel
// results leave on the m_ channel: a decoded byte, or a done result (is_done)
// carrying the string length when a zero byte arrives; m_last_of_run marks
// the last result caused by one input byte (at most two per byte)
// an accepted byte goes to the input register, its results to the result queue
// throughput: one byte per cycle; a byte that causes two results while a
// result is still waiting holds s_ready low until the queue is empty, set by the
// two-entry result queue behind the single decode stage
// max_out_len (apb, address 0) bounds the bytes produced per string; extra
// bytes are dropped until the zero byte; write it only while idle
// reset (aresetn low, synchronous): parser back to plain text, count zero,
// queue and input register empty, max_out_len back to 65535
// receiver stall: results wait in the queue; once it is full the input
// register holds and s_ready falls, no transaction is lost
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_is_done,
    output logic [15:0]      m_out_length,
    output logic             m_last_of_run,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic          in_vld_reg;
    logic [7:0]    in_byte_reg;
    logic [15:0]   max_len_reg;
    logic          process;
    logic          reg_hit;
    esc_pkg::res_t res0, res1, head;
    logic [1:0]    res_cnt, level;
    logic [2:0]    need;

    assign reg_hit = (paddr[2] == esc_pkg::REG_MAX_OUT_LEN[0]);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {16'h0000, max_len_reg} : 32'h0000_0000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= esc_pkg::MAX_OUT_LEN_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            max_len_reg <= pwdata[15:0];
        end
    end

    assign need    = {1'b0, level} + {1'b0, res_cnt};
    assign process = in_vld_reg && (need <= 3'd2);
    assign s_ready = !in_vld_reg || process;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    esc_parser #(
        .COUNT_BITS(COUNT_BITS)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cur_byte (in_byte_reg),
        .advance  (process),
        .limit    (max_len_reg),
        .res0     (res0),
        .res1     (res1),
        .res_cnt  (res_cnt)
    );

    esc_res_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (process),
        .push_cnt (res_cnt),
        .push0    (res0),
        .push1    (res1),
        .pop      (m_ready),
        .head     (head),
        .head_vld (m_valid),
        .level    (level)
    );

    assign m_out_byte    = head.out_byte;
    assign m_is_done     = head.is_done;
    assign m_out_length  = head.out_length;
    assign m_last_of_run = head.last_of_run;

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= 2'd2)
        else $error("result queue overfilled");

    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_done |-> m_out_byte == 8'h00 && m_last_of_run)
        else $error("done result carries a byte or is not last");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !process |=> in_vld_reg && $stable(in_byte_reg))
        else $error("pending input byte lost");

    a_byte_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_done |-> m_out_length == 16'h0000)
        else $error("byte result carries a length");

endmodule

`default_nettype wire
